[rtl/core/chord_template_matcher_core_assert.svh]
// Assertion helpers for the chord template matcher checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef CHORD_TEMPLATE_MATCHER_CORE_ASSERT_SVH
`define CHORD_TEMPLATE_MATCHER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/ctm_pkg.sv]
`timescale 1ns / 1ps

package ctm_pkg;

  localparam int WEIGHT_BITS_DEF = 12;
  localparam int BIN_W           = 12;
  localparam int BASS_W          = 5;
  localparam int ROOT_W          = 4;
  localparam int SHAPE_W         = 3;
  localparam int NUM_BINS        = 12;

  localparam logic [ROOT_W-1:0]  LAST_BIN = 4'd11;

  localparam logic [SHAPE_W-1:0] SHAPE_MAJOR = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_MINOR = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_DIM   = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_SUS4  = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_SUS2  = 3'd4;
  localparam logic [SHAPE_W-1:0] SHAPE_POWER = 3'd5;

  typedef struct packed {
    logic [ROOT_W-1:0]  root;
    logic [SHAPE_W-1:0] shape;
  } ctm_tag_t;

endpackage

[rtl/core/ctm_if.sv]
`timescale 1ns / 1ps

interface ctm_in_if;
  logic                                valid;
  logic                                ready;
  logic [ctm_pkg::BIN_W-1:0]           bin_weight;
  logic signed [ctm_pkg::BASS_W-1:0]   bass_class;

  modport source (output valid, output bin_weight, output bass_class, input ready);
  modport sink   (input valid, input bin_weight, input bass_class, output ready);
endinterface

interface ctm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          chord_valid;
  logic [ctm_pkg::ROOT_W-1:0]    chord_root;
  logic [ctm_pkg::SHAPE_W-1:0]   chord_shape;

  modport source (output valid, output chord_valid, output chord_root, output chord_shape,
                  input ready);
  modport sink   (input valid, input chord_valid, input chord_root, input chord_shape,
                  output ready);
endinterface

[rtl/core/ctm_ring.sv]
`timescale 1ns / 1ps

module ctm_ring #(
  parameter int WEIGHT_BITS = ctm_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          rotate,
  input  logic [WEIGHT_BITS-1:0]        din,
  input  logic [ctm_pkg::SHAPE_W-1:0]   shape,
  output logic [WEIGHT_BITS+1:0]        in_sum
);

  localparam int SW = WEIGHT_BITS + 2;

  logic [WEIGHT_BITS-1:0] ring [ctm_pkg::NUM_BINS];
  logic [WEIGHT_BITS-1:0] mid;
  logic [WEIGHT_BITS-1:0] hi;

  // Loading shifts bins in from the top, so after twelve beats entry 0 holds C.
  // Rotating by one per root keeps the current root at entry 0.
  always_ff @(posedge clk) begin
    if (load || rotate) begin
      for (int k = 0; k < ctm_pkg::NUM_BINS - 1; k++) begin
        ring[k] <= ring[k+1];
      end
      ring[ctm_pkg::NUM_BINS-1] <= load ? din : ring[0];
    end
  end

  // Template tones above the root, read from fixed taps.
  always_comb begin
    case (shape)
      ctm_pkg::SHAPE_MAJOR: begin
        mid = ring[4];
        hi  = ring[7];
      end
      ctm_pkg::SHAPE_MINOR: begin
        mid = ring[3];
        hi  = ring[7];
      end
      ctm_pkg::SHAPE_DIM: begin
        mid = ring[3];
        hi  = ring[6];
      end
      ctm_pkg::SHAPE_SUS4: begin
        mid = ring[5];
        hi  = ring[7];
      end
      ctm_pkg::SHAPE_SUS2: begin
        mid = ring[2];
        hi  = ring[7];
      end
      ctm_pkg::SHAPE_POWER: begin
        mid = '0;
        hi  = ring[7];
      end
      default: begin
        mid = '0;
        hi  = '0;
      end
    endcase
  end

  assign in_sum = SW'(ring[0]) + SW'(mid) + SW'(hi);

endmodule

[rtl/core/ctm_scorer.sv]
`timescale 1ns / 1ps

module ctm_scorer #(
  parameter int WEIGHT_BITS = ctm_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         issue,
  input  ctm_pkg::ctm_tag_t            tag_in,
  input  logic                         boost_in,
  input  logic [WEIGHT_BITS+1:0]       in_sum,
  input  logic [WEIGHT_BITS+3:0]       vec_total,
  output logic                         sc_valid,
  output ctm_pkg::ctm_tag_t            sc_tag,
  output logic signed [WEIGHT_BITS+15:0] sc_score,
  output logic                         busy
);

  localparam int SB = WEIGHT_BITS + 16;

  logic va, vb, vc, vd;
  ctm_pkg::ctm_tag_t tag_a, tag_b, tag_c, tag_d;
  logic boost_a, boost_b, boost_c;
  logic [WEIGHT_BITS+1:0] in_a;
  logic signed [SB-1:0] in_s;
  logic signed [SB-1:0] t_s;
  logic signed [SB-1:0] t38, t39;
  logic signed [SB-1:0] p96_b;
  logic signed [SB-1:0] base_c;
  logic signed [SB-1:0] x20;
  logic signed [SB-1:0] score_d;

  assign in_s = $signed(SB'(in_a));
  assign t_s  = $signed(SB'(vec_total));
  assign x20  = (base_c <<< 4) + (base_c <<< 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= issue;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  // Score scaled by 60 is 96*in - (36 + tones)*total; the boost then scales
  // by 23 instead of 20.
  always_ff @(posedge clk) begin
    t38     <= (t_s <<< 5) + (t_s <<< 3) - (t_s <<< 1);
    t39     <= (t_s <<< 5) + (t_s <<< 3) - t_s;
    tag_a   <= tag_in;
    boost_a <= boost_in;
    in_a    <= in_sum;
    tag_b   <= tag_a;
    boost_b <= boost_a;
    p96_b   <= (in_s <<< 6) + (in_s <<< 5);
    tag_c   <= tag_b;
    boost_c <= boost_b;
    base_c  <= p96_b - ((tag_b.shape == ctm_pkg::SHAPE_POWER) ? t38 : t39);
    tag_d   <= tag_c;
    score_d <= boost_c ? (x20 + (base_c <<< 1) + base_c) : x20;
  end

  assign sc_valid = vd;
  assign sc_tag   = tag_d;
  assign sc_score = score_d;
  assign busy     = va || vb || vc || vd;

endmodule

[rtl/core/chord_template_matcher_core.sv]
`timescale 1ns / 1ps

// Channel | Role  | Payload
// item    | sink  | bin_weight, bass_class
// result  | source| chord_valid, chord_root, chord_shape
//
// A weight beat is taken every cycle; the twelfth beat of a nonzero vector starts a
// scoring pass (72 templates through the one scorer pipeline, one per
// cycle, plus its drain) during which item.ready is low.
// A zero vector gives its result in the cycle after the twelfth beat.
// rst is synchronous and clears the control state; the weight ring is not cleared.
// A waiting result holds the result register; loading goes on, but the next
// twelfth beat waits until the result has been taken.
module chord_template_matcher_core #(
  parameter int WEIGHT_BITS = ctm_pkg::WEIGHT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ctm_in_if.sink        item,
  ctm_out_if.source     result
);

  localparam int WB = WEIGHT_BITS;
  localparam int TB = WEIGHT_BITS + 4;
  localparam int SB = WEIGHT_BITS + 16;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SCORE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                      state;
  logic [ctm_pkg::ROOT_W-1:0]      bin_index;
  logic [TB-1:0]                   weight_total;
  logic [TB-1:0]                   vec_total;
  logic signed [ctm_pkg::BASS_W-1:0] bass_latch;
  logic [ctm_pkg::ROOT_W-1:0]      root_cnt;
  logic [ctm_pkg::SHAPE_W-1:0]     shape_cnt;
  logic                            have;
  logic signed [SB-1:0]            best_score;
  ctm_pkg::ctm_tag_t               best_tag;
  logic                            res_valid;
  logic                            res_chord;
  ctm_pkg::ctm_tag_t               res_tag;

  logic                            item_fire;
  logic                            last_bin;
  logic [WB-1:0]                   w_in;
  logic [TB-1:0]                   total_next;
  logic                            issue;
  logic                            root_done;
  logic                            boost;
  ctm_pkg::ctm_tag_t               cur_tag;
  logic [WB+1:0]                   in_sum;
  logic                            sc_valid;
  ctm_pkg::ctm_tag_t               sc_tag;
  logic signed [SB-1:0]            sc_score;
  logic                            busy;
  logic                            take_best;

  assign last_bin   = bin_index == ctm_pkg::LAST_BIN;
  assign item.ready = (state == ST_LOAD) && !(last_bin && res_valid);
  assign item_fire  = item.valid && item.ready;
  assign w_in       = WB'(item.bin_weight);
  assign total_next = weight_total + TB'(w_in);

  assign issue         = state == ST_SCORE;
  assign root_done     = issue && (shape_cnt == ctm_pkg::SHAPE_POWER);
  assign cur_tag.root  = root_cnt;
  assign cur_tag.shape = shape_cnt;
  assign boost         = bass_latch == {1'b0, root_cnt};
  assign take_best     = sc_valid && (!have || (sc_score > best_score));

  ctm_ring #(.WEIGHT_BITS(WEIGHT_BITS)) u_ring (
    .clk    (clk),
    .load   (item_fire),
    .rotate (root_done),
    .din    (w_in),
    .shape  (shape_cnt),
    .in_sum (in_sum)
  );

  ctm_scorer #(.WEIGHT_BITS(WEIGHT_BITS)) u_scorer (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .tag_in    (cur_tag),
    .boost_in  (boost),
    .in_sum    (in_sum),
    .vec_total (vec_total),
    .sc_valid  (sc_valid),
    .sc_tag    (sc_tag),
    .sc_score  (sc_score),
    .busy      (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      bin_index    <= '0;
      weight_total <= '0;
      bass_latch   <= '1;
      root_cnt     <= '0;
      shape_cnt    <= '0;
      have         <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      if (take_best) begin
        have <= 1'b1;
      end
      case (state)
        ST_LOAD: begin
          if (item_fire) begin
            if (!last_bin) begin
              bin_index    <= bin_index + 1'b1;
              weight_total <= total_next;
            end else begin
              bin_index    <= '0;
              weight_total <= '0;
              bass_latch   <= item.bass_class;
              root_cnt     <= '0;
              shape_cnt    <= '0;
              have         <= 1'b0;
              if (total_next == '0) begin
                res_valid <= 1'b1;
              end else begin
                state <= ST_SCORE;
              end
            end
          end
        end
        ST_SCORE: begin
          if (root_done) begin
            shape_cnt <= '0;
            if (root_cnt == ctm_pkg::LAST_BIN) begin
              state <= ST_DRAIN;
            end else begin
              root_cnt <= root_cnt + 1'b1;
            end
          end else begin
            shape_cnt <= shape_cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            res_valid <= 1'b1;
            state     <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && last_bin) begin
      vec_total <= total_next;
      if (total_next == '0) begin
        res_chord <= 1'b0;
        res_tag   <= '0;
      end
    end
    if (take_best) begin
      best_score <= sc_score;
      best_tag   <= sc_tag;
    end
    if ((state == ST_DRAIN) && !busy) begin
      res_chord <= 1'b1;
      res_tag   <= best_tag;
    end
  end

  assign result.valid       = res_valid;
  assign result.chord_valid = res_chord;
  assign result.chord_root  = res_tag.root;
  assign result.chord_shape = res_tag.shape;

endmodule

[rtl/core/ctm_checker.sv]
`timescale 1ns / 1ps
`include "chord_template_matcher_core_assert.svh"

module ctm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          chord_valid,
  input logic [ctm_pkg::ROOT_W-1:0]    chord_root,
  input logic [ctm_pkg::SHAPE_W-1:0]   chord_shape
);

  logic [ctm_pkg::ROOT_W-1:0] item_cnt;

  // Position within the current vector, as seen from the port.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_cnt <= '0;
    end else if (item_valid && item_ready) begin
      item_cnt <= (item_cnt == ctm_pkg::LAST_BIN) ? '0 : item_cnt + 1'b1;
    end
  end

  `CTM_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(chord_valid) && $stable(chord_root) && $stable(chord_shape), "result beat changed while stalled")
  `CTM_ASSERT_NOW(a_no_chord_zero, res_valid && !chord_valid, chord_root == '0 && chord_shape == '0, "empty result carries a chord")
  `CTM_ASSERT_NOW(a_chord_range, res_valid && chord_valid, chord_root <= ctm_pkg::LAST_BIN && chord_shape <= ctm_pkg::SHAPE_POWER, "chord code out of range")
  `CTM_ASSERT_NOW(a_result_at_vector_end, $rose(res_valid), item_cnt == '0, "result appeared inside a vector")
  `CTM_ASSERT_NOW(a_twelfth_waits, res_valid && item_cnt == ctm_pkg::LAST_BIN, !item_ready, "twelfth beat taken while a result waits")

endmodule

bind chord_template_matcher_core ctm_checker u_ctm_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .chord_valid (result.chord_valid),
  .chord_root  (result.chord_root),
  .chord_shape (result.chord_shape)
);

[bench/chord_template_matcher_core_test.sv]
`timescale 1ns / 1ps

module chord_template_matcher_core_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic              found;
    ctm_pkg::ctm_tag_t tag;
  } chord_t;

  logic clk = 1'b0;
  logic rst;

  ctm_in_if  item_bus ();
  ctm_out_if result_bus ();

  chord_template_matcher_core DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always #5 clk = ~clk;

  // Predictor state for the vector being loaded.
  logic [ctm_pkg::BIN_W-1:0]         pitch_weights [ctm_pkg::NUM_BINS];
  int                                pitch_slot;
  int                                pitch_total;
  logic signed [ctm_pkg::BASS_W-1:0] bass_held;

  chord_t chord_queue [$];
  int     errors = 0;
  int     cycle_count = 0;
  bit     calm;
  int     hold_asked;
  int     hold_granted = 0;
  int     hold_left = 0;

  function automatic logic [11:0] shape_pattern(logic [ctm_pkg::SHAPE_W-1:0] shape);
    case (shape)
      ctm_pkg::SHAPE_MAJOR: return 12'h091;
      ctm_pkg::SHAPE_MINOR: return 12'h089;
      ctm_pkg::SHAPE_DIM:   return 12'h049;
      ctm_pkg::SHAPE_SUS4:  return 12'h0A1;
      ctm_pkg::SHAPE_SUS2:  return 12'h085;
      ctm_pkg::SHAPE_POWER: return 12'h081;
      default:              return 12'h000;
    endcase
  endfunction

  function automatic logic [11:0] chord_tones(int root, logic [ctm_pkg::SHAPE_W-1:0] shape);
    logic [23:0] wide;
    wide = {12'h000, shape_pattern(shape)} << root;
    return wide[11:0] | wide[23:12];
  endfunction

  // Scores all 72 templates on the stored vector, scaled by 1200 so that
  // everything stays integer; a later template needs a strictly higher score.
  function automatic chord_t pick_best_chord();
    chord_t      best;
    longint      best_score;
    longint      in_sum;
    longint      base;
    longint      score;
    logic [11:0] tones;
    best       = '0;
    best_score = 0;
    if (pitch_total == 0)
      return best;
    for (int r = 0; r < ctm_pkg::NUM_BINS; r++) begin
      for (int s = ctm_pkg::SHAPE_MAJOR; s <= ctm_pkg::SHAPE_POWER; s++) begin
        tones  = chord_tones(r, ctm_pkg::SHAPE_W'(s));
        in_sum = 0;
        for (int k = 0; k < ctm_pkg::NUM_BINS; k++)
          if (tones[k])
            in_sum += pitch_weights[k];
        base = 60 * in_sum - 36 * (pitch_total - in_sum)
               - longint'(pitch_total) * $countones(tones);
        score = (int'(bass_held) == r) ? base * 23 : base * 20;
        if (!best.found || score > best_score) begin
          best.found     = 1'b1;
          best.tag.root  = ctm_pkg::ROOT_W'(r);
          best.tag.shape = ctm_pkg::SHAPE_W'(s);
          best_score     = score;
        end
      end
    end
    return best;
  endfunction

  function automatic void absorb_bin(logic [ctm_pkg::BIN_W-1:0] weight,
                                     logic signed [ctm_pkg::BASS_W-1:0] bass);
    pitch_weights[pitch_slot] = weight;
    pitch_total += weight;
    if (pitch_slot < ctm_pkg::NUM_BINS - 1) begin
      pitch_slot++;
    end else begin
      bass_held = bass;
      chord_queue = {chord_queue, pick_best_chord()};
      pitch_slot  = 0;
      pitch_total = 0;
    end
  endfunction

  // Leaves valid high on return so that back-to-back calls keep the channel busy.
  task automatic send_bin(logic [ctm_pkg::BIN_W-1:0] weight,
                          logic signed [ctm_pkg::BASS_W-1:0] bass);
    if (!calm && $urandom_range(99) < 35) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.bin_weight <= weight;
    item_bus.bass_class <= bass;
    do @(posedge clk); while (!item_bus.ready);
    absorb_bin(weight, bass);
  endtask

  task automatic send_vector(logic [ctm_pkg::BIN_W-1:0] weights [ctm_pkg::NUM_BINS],
                             logic signed [ctm_pkg::BASS_W-1:0] bass);
    for (int k = 0; k < ctm_pkg::NUM_BINS - 1; k++)
      send_bin(weights[k], ctm_pkg::BASS_W'($urandom_range(31)));
    send_bin(weights[ctm_pkg::NUM_BINS-1], bass);
  endtask

  task automatic send_random_vector();
    logic [ctm_pkg::BIN_W-1:0]         weights [ctm_pkg::NUM_BINS];
    logic signed [ctm_pkg::BASS_W-1:0] bass;
    logic [11:0]                       tones;
    int                                kind;
    int                                root;
    int                                level;
    kind  = $urandom_range(99);
    root  = $urandom_range(ctm_pkg::NUM_BINS - 1);
    tones = chord_tones(root, ctm_pkg::SHAPE_W'($urandom_range(ctm_pkg::SHAPE_POWER)));
    level = $urandom_range(1, 4095);
    for (int k = 0; k < ctm_pkg::NUM_BINS; k++) begin
      if (kind < 60)
        weights[k] = tones[k] ? ctm_pkg::BIN_W'($urandom_range(600, 4095))
                              : ($urandom_range(2) == 0 ? '0
                                 : ctm_pkg::BIN_W'($urandom_range(400)));
      else if (kind < 72)
        weights[k] = ctm_pkg::BIN_W'($urandom_range(4095));
      else if (kind < 82)
        weights[k] = $urandom_range(1) ? ctm_pkg::BIN_W'(level) : '0;
      else if (kind < 90)
        weights[k] = (k == root) ? ctm_pkg::BIN_W'(level) : '0;
      else if (kind < 95)
        weights[k] = '0;
      else
        weights[k] = '1;
    end
    case ($urandom_range(3))
      0:       bass = ctm_pkg::BASS_W'(root);
      1:       bass = ctm_pkg::BASS_W'((root + 7) % ctm_pkg::NUM_BINS);
      2:       bass = ctm_pkg::BASS_W'($urandom_range(31));
      default: bass = -1;
    endcase
    send_vector(weights, bass);
  endtask

  task automatic check_chord_beat();
    chord_t seen;
    chord_t want;
    seen.found     = result_bus.chord_valid;
    seen.tag.root  = result_bus.chord_root;
    seen.tag.shape = result_bus.chord_shape;
    if (chord_queue.size() == 0) begin
      $display("%0t: unexpected chord beat valid=%0d root=%0d shape=%0d", $time,
               seen.found, seen.tag.root, seen.tag.shape);
      errors++;
      return;
    end
    want = chord_queue.pop_front();
    if (seen.found !== want.found) begin
      $display("%0t: chord_valid expected %0d, actual %0d", $time, want.found, seen.found);
      errors++;
    end
    if (seen.tag.root !== want.tag.root) begin
      $display("%0t: chord_root expected %0d, actual %0d", $time,
               want.tag.root, seen.tag.root);
      errors++;
    end
    if (seen.tag.shape !== want.tag.shape) begin
      $display("%0t: chord_shape expected %0d, actual %0d", $time,
               want.tag.shape, seen.tag.shape);
      errors++;
    end
  endtask

  // Result side: checks each beat, then picks ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      check_chord_beat();
    if (hold_asked != hold_granted) begin
      hold_left    = HOLD_CYCLES;
      hold_granted = hold_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_zero_vector();
    logic [ctm_pkg::BIN_W-1:0] weights [ctm_pkg::NUM_BINS];
    foreach (weights[k])
      weights[k] = '0;
    send_vector(weights, -1);
  endtask

  // Full-scale weights; the bass on the last beat is outside 0..11 and must not boost.
  task automatic test_full_scale();
    logic [ctm_pkg::BIN_W-1:0] weights [ctm_pkg::NUM_BINS];
    foreach (weights[k])
      weights[k] = '1;
    send_vector(weights, 5'sd12);
  endtask

  task automatic test_random_chords(int vectors);
    for (int v = 0; v < vectors; v++) begin
      calm = (v < 10);
      send_random_vector();
    end
    calm = 1'b0;
  endtask

  // The result side stops for a long while so the second vector stalls on its last beat.
  task automatic test_result_backpressure();
    calm = 1'b1;
    hold_asked++;
    repeat (3) send_random_vector();
    calm = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_random_vector();
    item_bus.valid <= 1'b0;
    wait (chord_queue.size() == 0);
    @(posedge clk);
    send_random_vector();
  endtask

  initial begin
    rst                 <= 1'b1;
    item_bus.valid      <= 1'b0;
    item_bus.bin_weight <= '0;
    item_bus.bass_class <= '0;
    pitch_slot  = 0;
    pitch_total = 0;
    bass_held   = -1;
    calm        = 1'b0;
    hold_asked  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_vector();
    test_full_scale();
    test_random_chords(50);
    test_result_backpressure();
    test_drain_pause();

    item_bus.valid <= 1'b0;
    wait (chord_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
